>>> hdl/ycb2bgr_pkg.sv
// ----------------------------------------------------------------------------
// ycb2bgr_pkg
// Shared types and fixed rational constants for the YCbCr 4:2:2 pair to BGR
// converter.
// ----------------------------------------------------------------------------
package ycb2bgr_pkg;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
   } req_word_type;

   typedef struct packed {
      logic [7:0] blue_first;
      logic [7:0] green_first;
      logic [7:0] red_first;
      logic [7:0] blue_second;
      logic [7:0] green_second;
      logic [7:0] red_second;
   } rsp_word_type;

   // bt.601 studio-range coefficients as exact rationals
   localparam longint K_Y_NUM  = 64'sd255;
   localparam longint K_Y_DEN  = 64'sd219;
   localparam longint K_RV_NUM = 64'sd178755;
   localparam longint K_RV_DEN = 64'sd112000;
   localparam longint K_GU_NUM = 64'sd25756020;
   localparam longint K_GU_DEN = 64'sd65744000;
   localparam longint K_GV_NUM = 64'sd53447745;
   localparam longint K_GV_DEN = 64'sd65744000;
   localparam longint K_BU_NUM = 64'sd225930;
   localparam longint K_BU_DEN = 64'sd112000;

   localparam logic [7:0] LUMA_OFFSET   = 8'd16;
   localparam logic [7:0] CHROMA_OFFSET = 8'd128;
   localparam logic [7:0] BYTE_MAX      = 8'd255;

endpackage

>>> hdl/ycbcr422_pair_to_bgr_top.sv
// ----------------------------------------------------------------------------
// ycbcr422_pair_to_bgr_top
// Converts one packed YCbCr 4:2:2 pixel pair into two BGR pixels that share
// the chroma, using studio-range BT.601 equations in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word per pixel pair (Y0, Cb, Y1, Cr), taken at an edge
//   with req_valid high and req_stall low.
//   rsp channel: one word per accepted request with two clamped BGR pixels,
//   taken at an edge with rsp_valid high and rsp_stall low.
//   A request word lands in an input register, and the coefficient
//   multiplies, sums and clamps run between that register and the result
//   register. Throughput is one word per cycle while rsp_stall is low, set by
//   the single pass of multiply-add logic between the two registers.
//   A stalled result word holds; the input register still fills behind it,
//   and req_stall rises only when both registers are occupied.
//   Synchronous reset empties both registers; no words are in flight after.
//   COEF_FRAC_BITS sets the coefficient fraction bits (8 to 16).
// ----------------------------------------------------------------------------
module ycbcr422_pair_to_bgr_top
   import ycb2bgr_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   localparam int SUM_W = COEF_FRAC_BITS + 12;
   localparam longint FX_ONE = longint'(1) << COEF_FRAC_BITS;

   localparam longint K_Y_L  = (K_Y_NUM  * FX_ONE + K_Y_DEN  / 2) / K_Y_DEN;
   localparam longint K_RV_L = (K_RV_NUM * FX_ONE + K_RV_DEN / 2) / K_RV_DEN;
   localparam longint K_GU_L = (K_GU_NUM * FX_ONE + K_GU_DEN / 2) / K_GU_DEN;
   localparam longint K_GV_L = (K_GV_NUM * FX_ONE + K_GV_DEN / 2) / K_GV_DEN;
   localparam longint K_BU_L = (K_BU_NUM * FX_ONE + K_BU_DEN / 2) / K_BU_DEN;

   localparam logic signed [SUM_W-1:0] K_Y  = SUM_W'(K_Y_L);
   localparam logic signed [SUM_W-1:0] K_RV = SUM_W'(K_RV_L);
   localparam logic signed [SUM_W-1:0] K_GU = SUM_W'(K_GU_L);
   localparam logic signed [SUM_W-1:0] K_GV = SUM_W'(K_GV_L);
   localparam logic signed [SUM_W-1:0] K_BU = SUM_W'(K_BU_L);

   logic         pipe_valid_ff;
   logic         pipe_valid_in;
   req_word_type pipe_data_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_word_type rsp_data_ff;
   rsp_word_type rsp_data_in;
   logic         adv_rsp;
   logic         adv_pipe;

   logic signed [SUM_W-1:0] y0_ext;
   logic signed [SUM_W-1:0] y1_ext;
   logic signed [SUM_W-1:0] pb_ext;
   logic signed [SUM_W-1:0] pr_ext;
   logic signed [SUM_W-1:0] ys0;
   logic signed [SUM_W-1:0] ys1;
   logic signed [SUM_W-1:0] b_term;
   logic signed [SUM_W-1:0] gu_term;
   logic signed [SUM_W-1:0] gv_term;
   logic signed [SUM_W-1:0] r_term;

   function automatic logic [7:0] clamp_byte(input logic signed [SUM_W-1:0] sum);
      logic [SUM_W-1:0] whole;
      logic [7:0]       res;
      whole = SUM_W'($unsigned(sum) >> COEF_FRAC_BITS);
      if (sum < 0) begin
         res = 8'd0;
      end else if (whole > SUM_W'(BYTE_MAX)) begin
         res = BYTE_MAX;
      end else begin
         res = whole[7:0];
      end
      return res;
   endfunction

   // handshake
   assign adv_rsp   = !rsp_valid_ff || !rsp_stall;
   assign adv_pipe  = !pipe_valid_ff || adv_rsp;
   assign req_stall = !adv_pipe;

   always_comb begin
      pipe_valid_in = pipe_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (adv_pipe) begin
         pipe_valid_in = req_valid;
      end
      if (adv_rsp) begin
         rsp_valid_in = pipe_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pipe_valid_ff <= pipe_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_pipe && req_valid) begin
         pipe_data_ff <= req_data;
      end
      if (adv_rsp && pipe_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // offset removal
   assign y0_ext = $signed(SUM_W'(pipe_data_ff.luma_first))  - $signed(SUM_W'(LUMA_OFFSET));
   assign y1_ext = $signed(SUM_W'(pipe_data_ff.luma_second)) - $signed(SUM_W'(LUMA_OFFSET));
   assign pb_ext = $signed(SUM_W'(pipe_data_ff.chroma_blue)) - $signed(SUM_W'(CHROMA_OFFSET));
   assign pr_ext = $signed(SUM_W'(pipe_data_ff.chroma_red))  - $signed(SUM_W'(CHROMA_OFFSET));

   // coefficient products
   assign ys0     = K_Y  * y0_ext;
   assign ys1     = K_Y  * y1_ext;
   assign b_term  = K_BU * pb_ext;
   assign gu_term = K_GU * pb_ext;
   assign gv_term = K_GV * pr_ext;
   assign r_term  = K_RV * pr_ext;

   always_comb begin
      rsp_data_in.blue_first   = clamp_byte(ys0 + b_term);
      rsp_data_in.green_first  = clamp_byte(ys0 - gu_term - gv_term);
      rsp_data_in.red_first    = clamp_byte(ys0 + r_term);
      rsp_data_in.blue_second  = clamp_byte(ys1 + b_term);
      rsp_data_in.green_second = clamp_byte(ys1 - gu_term - gv_term);
      rsp_data_in.red_second   = clamp_byte(ys1 + r_term);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // assertions
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (pipe_valid_ff && rsp_valid_ff))
      else $error("req_stall with a free register");

   a_word_moves_forward: assert property (@(posedge clock) disable iff (reset)
      (pipe_valid_ff && adv_rsp) |=> rsp_valid_ff)
      else $error("word lost between input and result register");

   a_rsp_rise_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pipe_valid_ff))
      else $error("result word appeared without an input word");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !pipe_valid_ff))
      else $error("registers not empty after reset");

endmodule

>>> verif/ycbcr422_pair_to_bgr_checker.sv
// ----------------------------------------------------------------------------
// ycbcr422_pair_to_bgr_checker
// Watches the request and result channels of the 4:2:2 pair to BGR converter.
// Every accepted request word is converted here in signed fixed point, and the
// expected BGR word is queued. Every accepted result word is compared field by
// field with the oldest queued word. Mismatches and unexpected results are
// counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module ycbcr422_pair_to_bgr_checker
   import ycb2bgr_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_data,
   output int           mismatch_count,
   output int           pending_count,
   output int           checked_count
);

   rsp_word_type pending_bgr[$];
   string        field_names[6] = '{"blue_first", "green_first", "red_first",
                                    "blue_second", "green_second", "red_second"};

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      checked_count  = 0;
   end

   function automatic longint fixed_coef(longint num, longint den);
      return (num * (longint'(1) << COEF_FRAC_BITS) + den / 2) / den;
   endfunction

   function automatic logic [7:0] sum_to_byte(longint sum);
      longint whole;
      if (sum < 0)
         return 8'd0;
      whole = sum >>> COEF_FRAC_BITS;
      if (whole > longint'(BYTE_MAX))
         return BYTE_MAX;
      return whole[7:0];
   endfunction

   function automatic rsp_word_type convert_pair_bgr(req_word_type w);
      longint       k_y, k_rv, k_gu, k_gv, k_bu;
      longint       pb, pr, ys_first, ys_second;
      rsp_word_type p;
      k_y  = fixed_coef(K_Y_NUM, K_Y_DEN);
      k_rv = fixed_coef(K_RV_NUM, K_RV_DEN);
      k_gu = fixed_coef(K_GU_NUM, K_GU_DEN);
      k_gv = fixed_coef(K_GV_NUM, K_GV_DEN);
      k_bu = fixed_coef(K_BU_NUM, K_BU_DEN);
      pb = longint'(w.chroma_blue) - longint'(CHROMA_OFFSET);
      pr = longint'(w.chroma_red) - longint'(CHROMA_OFFSET);
      ys_first  = k_y * (longint'(w.luma_first) - longint'(LUMA_OFFSET));
      ys_second = k_y * (longint'(w.luma_second) - longint'(LUMA_OFFSET));
      p.blue_first   = sum_to_byte(ys_first + k_bu * pb);
      p.green_first  = sum_to_byte(ys_first - k_gu * pb - k_gv * pr);
      p.red_first    = sum_to_byte(ys_first + k_rv * pr);
      p.blue_second  = sum_to_byte(ys_second + k_bu * pb);
      p.green_second = sum_to_byte(ys_second - k_gu * pb - k_gv * pr);
      p.red_second   = sum_to_byte(ys_second + k_rv * pr);
      return p;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      logic [7:0]   want_field, got_field;
      if (reset) begin
         pending_bgr.delete();
      end else begin
         if (req_valid && !req_stall)
            pending_bgr.push_back(convert_pair_bgr(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (pending_bgr.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 30)
                  $display("%0t: unexpected bgr word, expected none, actual %h",
                           $time, rsp_data);
            end else begin
               want = pending_bgr.pop_front();
               checked_count++;
               for (int i = 0; i < 6; i++) begin
                  want_field = want[47 - 8 * i -: 8];
                  got_field  = rsp_data[47 - 8 * i -: 8];
                  if (want_field !== got_field) begin
                     mismatch_count++;
                     if (mismatch_count <= 30)
                        $display("%0t: %s expected %0d actual %0d", $time,
                                 field_names[i], want_field, got_field);
                  end
               end
            end
         end
      end
      pending_count = pending_bgr.size();
   end

endmodule

>>> verif/tb_ycbcr422_pair_to_bgr_top.sv
// ----------------------------------------------------------------------------
// tb_ycbcr422_pair_to_bgr_top
// Drives the 4:2:2 pair to BGR converter with a directed set of corner words
// (black, white, chroma extremes, clamp at both ends) and then random words,
// with random bursts of request gaps and result stalls in some phases and
// none in others. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ycbcr422_pair_to_bgr_top
   import ycb2bgr_pkg::*;
();

   localparam int FRAC_BITS    = 12;
   localparam int RANDOM_WORDS = 950;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   int mismatch_count, pending_count, checked_count;
   int gap_pct   = 0;
   int stall_pct = 0;
   int sent_count = 0;

   ycbcr422_pair_to_bgr_top #(.COEF_FRAC_BITS(FRAC_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   ycbcr422_pair_to_bgr_checker #(.COEF_FRAC_BITS(FRAC_BITS)) bgr_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("RESULT: ERROR");
      $finish;
   end

   // result side stall bursts
   initial begin
      forever begin
         @(posedge clock);
         if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [7:0] boundary_byte();
      case ($urandom_range(0, 5))
         0: return 8'($urandom_range(0, 20));
         1: return 8'($urandom_range(230, 255));
         2: return 8'($urandom_range(120, 136));
         3: return 8'd0;
         4: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic req_word_type random_pair();
      req_word_type w;
      w = req_word_type'($urandom);
      case ($urandom_range(0, 3))
         0: begin
            w.luma_first  = boundary_byte();
            w.luma_second = boundary_byte();
         end
         1: begin
            w.chroma_blue = boundary_byte();
            w.chroma_red  = boundary_byte();
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic send_word(req_word_type w);
      req_data  <= w;
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      sent_count++;
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   initial begin
      req_word_type corner_words[18];
      corner_words = '{
         {8'd0,   8'd0,   8'd0,   8'd0},
         {8'd255, 8'd255, 8'd255, 8'd255},
         {8'd16,  8'd128, 8'd16,  8'd128},
         {8'd235, 8'd128, 8'd235, 8'd128},
         {8'd0,   8'd128, 8'd255, 8'd128},
         {8'd128, 8'd0,   8'd128, 8'd0},
         {8'd128, 8'd255, 8'd128, 8'd0},
         {8'd128, 8'd0,   8'd128, 8'd255},
         {8'd128, 8'd255, 8'd128, 8'd255},
         {8'd16,  8'd16,  8'd235, 8'd240},
         {8'd235, 8'd240, 8'd16,  8'd16},
         {8'd81,  8'd90,  8'd145, 8'd240},
         {8'd145, 8'd54,  8'd41,  8'd34},
         {8'd17,  8'd129, 8'd234, 8'd127},
         {8'd170, 8'd85,  8'd85,  8'd170},
         {8'd85,  8'd170, 8'd170, 8'd85},
         {8'd1,   8'd2,   8'd4,   8'd8},
         {8'd254, 8'd253, 8'd251, 8'd247}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (corner_words[i])
         send_word(corner_words[i]);
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i < 300) begin
            gap_pct   = 40;
            stall_pct = 40;
         end else if (i < 500) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else if (i < 800) begin
            gap_pct   = 15;
            stall_pct = 20;
         end else begin
            gap_pct   = 0;
            stall_pct = 0;
         end
         send_word(random_pair());
      end
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      $display("run covered %0d pixel-pair words (%0d corner words), %0d bgr words checked",
               sent_count, $size(corner_words), checked_count);
      $display("gap and stall bursts in early and middle phases, none at the end");
      if (mismatch_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
hdl/ycb2bgr_pkg.sv
hdl/ycbcr422_pair_to_bgr_top.sv
verif/ycbcr422_pair_to_bgr_checker.sv
verif/tb_ycbcr422_pair_to_bgr_top.sv
